/* hdl/mbrtu_pkg.sv */
// Shared types, constants and CRC function of the Modbus RTU request encoder.
package mbrtu_pkg;

    typedef enum logic [1:0] {
        FUNC_READ_HOLD    = 2'd0,
        FUNC_WRITE_SINGLE = 2'd1,
        FUNC_WRITE_MULTI  = 2'd2,
        FUNC_DATA_WORD    = 2'd3
    } t_func;

    localparam logic [7:0] FC_READ_HOLD    = 8'h03;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int HDR_BYTES = 7;
    localparam int WORDS_W   = 7;
    localparam int IDX_W     = 4;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    // One command from the front to the back: a run of literal bytes,
    // optionally followed by the two CRC bytes, or a single error result.
    typedef struct packed {
        logic                        err;
        logic                        restart;
        logic                        add_crc;
        logic [2:0]                  nbytes;
        logic [HDR_BYTES-1:0][7:0]   bytes;
    } t_cmd;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
        logic       err;
    } t_res;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* hdl/mbrtu_front.sv */
// Front part: classifies request items against the open frame and builds commands.
module mbrtu_front #(
    parameter int MAX_REGS = 123
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [1:0]           i_func,
    input  logic [15:0]          i_reg_addr,
    input  logic [15:0]          i_quantity,
    input  logic [15:0]          i_data_word,
    input  logic [7:0]           i_slave_address,
    output mbrtu_pkg::t_cmd      o_cmd
);

    logic                              r_open;
    logic [mbrtu_pkg::WORDS_W-1:0]     r_words;
    logic                              n_open;
    logic [mbrtu_pkg::WORDS_W-1:0]     n_words;
    logic [mbrtu_pkg::WORDS_W-1:0]     w_words_dec;
    mbrtu_pkg::t_func                  w_func;
    logic [7:0]                        w_code;

    assign w_func      = mbrtu_pkg::t_func'(i_func);
    assign w_words_dec = r_words - mbrtu_pkg::WORDS_W'(1);

    always_comb begin
        o_cmd         = '0;
        n_open        = r_open;
        n_words       = r_words;
        w_code        = mbrtu_pkg::FC_READ_HOLD;
        unique case (w_func)
            mbrtu_pkg::FUNC_READ_HOLD:    w_code = mbrtu_pkg::FC_READ_HOLD;
            mbrtu_pkg::FUNC_WRITE_SINGLE: w_code = mbrtu_pkg::FC_WRITE_SINGLE;
            mbrtu_pkg::FUNC_WRITE_MULTI:  w_code = mbrtu_pkg::FC_WRITE_MULTI;
            mbrtu_pkg::FUNC_DATA_WORD:    w_code = mbrtu_pkg::FC_WRITE_MULTI;
        endcase
        if (w_func == mbrtu_pkg::FUNC_DATA_WORD) begin
            if (!r_open) begin
                o_cmd.err = 1'b1;
            end else begin
                o_cmd.nbytes   = 3'd2;
                o_cmd.bytes[0] = i_data_word[15:8];
                o_cmd.bytes[1] = i_data_word[7:0];
                o_cmd.add_crc  = (w_words_dec == '0);
                n_words        = w_words_dec;
                n_open         = (w_words_dec != '0);
            end
        end else if (r_open) begin
            o_cmd.err = 1'b1;
        end else if (w_func == mbrtu_pkg::FUNC_WRITE_MULTI &&
                     i_quantity > 16'(MAX_REGS)) begin
            o_cmd.err = 1'b1;
        end else begin
            o_cmd.restart  = 1'b1;
            o_cmd.bytes[0] = i_slave_address;
            o_cmd.bytes[1] = w_code;
            o_cmd.bytes[2] = i_reg_addr[15:8];
            o_cmd.bytes[3] = i_reg_addr[7:0];
            o_cmd.bytes[4] = i_quantity[15:8];
            o_cmd.bytes[5] = i_quantity[7:0];
            o_cmd.bytes[6] = {i_quantity[6:0], 1'b0};
            if (w_func == mbrtu_pkg::FUNC_WRITE_MULTI) begin
                o_cmd.nbytes  = 3'd7;
                o_cmd.add_crc = (i_quantity == '0);
                if (i_quantity != '0) begin
                    n_words = i_quantity[mbrtu_pkg::WORDS_W-1:0];
                    n_open  = 1'b1;
                end
            end else begin
                o_cmd.nbytes  = 3'd6;
                o_cmd.add_crc = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_words <= '0;
        end else if (i_accept) begin
            r_open  <= n_open;
            r_words <= n_words;
        end
    end

endmodule

/* hdl/mbrtu_cmdq.sv */
// Short command queue between the front and back parts.
module mbrtu_cmdq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mbrtu_pkg::t_cmd  i_cmd,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output mbrtu_pkg::t_cmd  o_cmd
);

    mbrtu_pkg::t_cmd                   r_mem [mbrtu_pkg::QDEPTH];
    logic [mbrtu_pkg::QPTR_W-1:0]      r_wr;
    logic [mbrtu_pkg::QPTR_W-1:0]      r_rd;
    logic [mbrtu_pkg::QCNT_W-1:0]      r_cnt;
    logic                              w_push;
    logic                              w_pop;

    assign o_full  = (r_cnt == mbrtu_pkg::QCNT_W'(mbrtu_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + mbrtu_pkg::QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + mbrtu_pkg::QPTR_W'(1);
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + mbrtu_pkg::QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - mbrtu_pkg::QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hdl/mbrtu_back.sv */
// Back part: serializes command bytes, runs the CRC and queues result items.
module mbrtu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  mbrtu_pkg::t_cmd  i_cmd,
    output logic             o_cmd_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output mbrtu_pkg::t_res  o_res
);

    logic [mbrtu_pkg::IDX_W-1:0]       r_idx;
    logic [15:0]                       r_crc;
    mbrtu_pkg::t_res                   r_oq [mbrtu_pkg::QDEPTH];
    logic [mbrtu_pkg::QPTR_W-1:0]      r_owr;
    logic [mbrtu_pkg::QPTR_W-1:0]      r_ord;
    logic [mbrtu_pkg::QCNT_W-1:0]      r_ocnt;

    logic [mbrtu_pkg::IDX_W-1:0]       w_total;
    logic [mbrtu_pkg::IDX_W-1:0]       w_nbytes;
    logic                              w_out_full;
    logic                              w_emit;
    logic                              w_is_data;
    logic                              w_last;
    logic [7:0]                        w_byte;
    logic [15:0]                       w_crc_base;
    logic [15:0]                       w_crc_next;
    logic                              w_opop;
    mbrtu_pkg::t_res                   w_res;

    assign w_nbytes   = {1'b0, i_cmd.nbytes};
    assign w_total    = i_cmd.err ? mbrtu_pkg::IDX_W'(1)
                                  : w_nbytes + (i_cmd.add_crc ? mbrtu_pkg::IDX_W'(2) : '0);
    assign w_out_full = (r_ocnt == mbrtu_pkg::QCNT_W'(mbrtu_pkg::QDEPTH));
    assign w_emit     = i_cmd_valid && !w_out_full;
    assign w_is_data  = !i_cmd.err && (r_idx < w_nbytes);
    assign w_last     = (r_idx == w_total - mbrtu_pkg::IDX_W'(1));
    assign o_cmd_pop  = w_emit && w_last;

    // Pick a zero byte for an error, else the literal byte, else the CRC low then high byte.
    always_comb begin
        priority if (i_cmd.err) begin
            w_byte = 8'h00;
        end else if (w_is_data) begin
            w_byte = i_cmd.bytes[r_idx[2:0]];
        end else if (r_idx == w_nbytes) begin
            w_byte = r_crc[7:0];
        end else begin
            w_byte = r_crc[15:8];
        end
    end

    assign w_crc_base = (i_cmd.restart && r_idx == '0) ? mbrtu_pkg::CRC_INIT : r_crc;
    assign w_crc_next = mbrtu_pkg::crc_byte(w_crc_base, w_byte);

    assign w_res.tx_byte = w_byte;
    assign w_res.last    = w_last;
    assign w_res.err     = i_cmd.err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_crc <= mbrtu_pkg::CRC_INIT;
        end else if (w_emit) begin
            r_idx <= w_last ? '0 : r_idx + mbrtu_pkg::IDX_W'(1);
            if (w_is_data) begin
                r_crc <= w_crc_next;
            end
        end
    end

    // Result queue
    assign o_empty = (r_ocnt == '0);
    assign o_res   = r_oq[r_ord];
    assign w_opop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_oq[r_owr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= '0;
            r_ord  <= '0;
            r_ocnt <= '0;
        end else begin
            if (w_emit) begin
                r_owr <= r_owr + mbrtu_pkg::QPTR_W'(1);
            end
            if (w_opop) begin
                r_ord <= r_ord + mbrtu_pkg::QPTR_W'(1);
            end
            unique case ({w_emit, w_opop})
                2'b10:   r_ocnt <= r_ocnt + mbrtu_pkg::QCNT_W'(1);
                2'b01:   r_ocnt <= r_ocnt - mbrtu_pkg::QCNT_W'(1);
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

endmodule

/* hdl/modbus_rtu_request_encoder.sv */
// Top level of the Modbus RTU request encoder: front, command queue and back.
//
// Input channel (push/full): one request item per accepted push. func 0 and 1
// give a full 8-byte frame; func 2 opens a write-multiple frame with 7 header
// bytes; func 3 carries one data word (2 bytes) and, for the final word, the
// two CRC bytes. Mismatched items give one error result (tx_byte 0, flagged).
// Result channel (empty/pop): one item per frame byte, oldest on the ports
// while empty is low; last_byte marks the final byte caused by an input item.
// Config: i_cfg_we writes i_cfg_data into the slave address (reset value 1).
// An item's bytes pass the registered command queue, then the result queue.
// Throughput: one result byte per cycle while the result queue has room, set
// by the single CRC byte unit in the back part. The front accepts while the
// two-entry command queue has room, so pushes overlap the serialization of
// earlier items.
// Reset: all queues empty, no frame open, CRC at FFFF.
// When pop stays low, the two-entry result queue fills, the back stops, then
// the command queue fills and full rises; nothing is dropped.
module modbus_rtu_request_encoder #(
    parameter int MAX_REGS = 123
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         push,
    output logic         full,
    input  logic [1:0]   i_func,
    input  logic [15:0]  i_reg_addr,
    input  logic [15:0]  i_quantity,
    input  logic [15:0]  i_data_word,
    output logic         empty,
    input  logic         pop,
    output logic [7:0]   o_tx_byte,
    output logic         o_last_byte,
    output logic         o_request_error,
    input  logic         i_cfg_we,
    input  logic [7:0]   i_cfg_data
);

    logic [7:0]          r_slave_address;
    logic                w_accept;
    mbrtu_pkg::t_cmd     w_front_cmd;
    mbrtu_pkg::t_cmd     w_head_cmd;
    logic                w_cmd_valid;
    logic                w_cmd_pop;
    mbrtu_pkg::t_res     w_res;

    // Hold the slave address; it is sampled when a header item is classified.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address <= 8'h01;
        end else if (i_cfg_we) begin
            r_slave_address <= i_cfg_data;
        end
    end

    assign w_accept = push && !full;

    mbrtu_front #(
        .MAX_REGS (MAX_REGS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_func          (i_func),
        .i_reg_addr      (i_reg_addr),
        .i_quantity      (i_quantity),
        .i_data_word     (i_data_word),
        .i_slave_address (r_slave_address),
        .o_cmd           (w_front_cmd)
    );

    mbrtu_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (w_front_cmd),
        .o_full  (full),
        .i_pop   (w_cmd_pop),
        .o_valid (w_cmd_valid),
        .o_cmd   (w_head_cmd)
    );

    mbrtu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_head_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (w_res)
    );

    assign o_tx_byte       = w_res.tx_byte;
    assign o_last_byte     = w_res.last;
    assign o_request_error = w_res.err;

    // Both queues come out of reset empty.
    a_reset_empty : assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // An error result is a lone zero byte that closes its item.
    a_error_shape : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_request_error) |-> (o_last_byte && o_tx_byte == 8'h00))
        else $error("malformed error result");

    // The back retires a command only when one is queued.
    a_cmd_pop_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid)
        else $error("command retired from empty queue");

endmodule

/* tb/tb_modbus_rtu_request_encoder.sv */
// Self-checking testbench of the Modbus RTU request encoder: directed table, then random frames.
`timescale 1ns / 1ps

module tb_modbus_rtu_request_encoder;

    localparam int MAX_REGS      = 123;
    localparam int N_DIRECTED    = 23;
    localparam int PHASE_ITEMS   = 34;
    localparam int LONG_WORDS    = 20;
    localparam int HOLD_CYCLES   = 150;
    localparam int WATCHDOG_IDLE = 1000;
    localparam int N_PHASES      = 4;

    // One expected frame byte, or an error flag item.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } t_frame_byte;

    // One row of the directed table. A row may first load a new slave
    // address; rows with typed_err carry their expected error item inline.
    typedef struct packed {
        logic             set_cfg;
        logic [7:0]       cfg_val;
        mbrtu_pkg::t_func func;
        logic [15:0]      addr;
        logic [15:0]      qty;
        logic [15:0]      word;
        logic             typed_err;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_func;
    logic [15:0] i_reg_addr;
    logic [15:0] i_quantity;
    logic [15:0] i_data_word;
    logic        empty;
    logic        pop;
    logic [7:0]  o_tx_byte;
    logic        o_last_byte;
    logic        o_request_error;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_data;

    // Predictor state: slave address register and the running frame state.
    logic [7:0]  pred_slave;
    logic [15:0] pred_crc;
    logic [6:0]  pred_words;
    logic        pred_open;

    logic [7:0]  frame_build[$];
    t_frame_byte frame_bytes_q[$];
    t_frame_byte want;

    int fail_cnt;
    int items_sent;
    int idle_cycles;
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_req;

    t_row directed_rows [N_DIRECTED];

    modbus_rtu_request_encoder #(
        .MAX_REGS(MAX_REGS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_func         (i_func),
        .i_reg_addr     (i_reg_addr),
        .i_quantity     (i_quantity),
        .i_data_word    (i_data_word),
        .empty          (empty),
        .pop            (pop),
        .o_tx_byte      (o_tx_byte),
        .o_last_byte    (o_last_byte),
        .o_request_error(o_request_error),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // CRC-16/MODBUS, one byte folded in LSB first.
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ mbrtu_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        frame_build.push_back(b);
        pred_crc = crc16_fold(pred_crc, b);
    endfunction

    // Append the CRC, low byte first; it is not folded back in.
    function automatic void emit_crc();
        frame_build.push_back(pred_crc[7:0]);
        frame_build.push_back(pred_crc[15:8]);
    endfunction

    function automatic void expect_error();
        frame_bytes_q.push_back('{data: 8'h00, last: 1'b1, err: 1'b1});
    endfunction

    // Work out the frame bytes one accepted item causes and queue them.
    function automatic void encode_request(input mbrtu_pkg::t_func f, input logic [15:0] a,
                                           input logic [15:0] q, input logic [15:0] w);
        frame_build.delete();
        if (f == mbrtu_pkg::FUNC_DATA_WORD) begin
            if (!pred_open) begin
                expect_error();
                return;
            end
            emit_byte(w[15:8]);
            emit_byte(w[7:0]);
            pred_words = pred_words - 7'd1;
            if (pred_words == 7'd0) begin
                emit_crc();
                pred_open = 1'b0;
            end
        end else begin
            // Drop headers that arrive mid-frame or ask for too many registers.
            if (pred_open || (f == mbrtu_pkg::FUNC_WRITE_MULTI && q > MAX_REGS)) begin
                expect_error();
                return;
            end
            pred_crc = mbrtu_pkg::CRC_INIT;
            emit_byte(pred_slave);
            case (f)
                mbrtu_pkg::FUNC_READ_HOLD:    emit_byte(mbrtu_pkg::FC_READ_HOLD);
                mbrtu_pkg::FUNC_WRITE_SINGLE: emit_byte(mbrtu_pkg::FC_WRITE_SINGLE);
                default:                      emit_byte(mbrtu_pkg::FC_WRITE_MULTI);
            endcase
            emit_byte(a[15:8]);
            emit_byte(a[7:0]);
            emit_byte(q[15:8]);
            emit_byte(q[7:0]);
            if (f == mbrtu_pkg::FUNC_WRITE_MULTI) begin
                emit_byte({q[6:0], 1'b0});
                if (q == 16'd0) begin
                    emit_crc();
                end else begin
                    pred_words = q[6:0];
                    pred_open  = 1'b1;
                end
            end else begin
                emit_crc();
            end
        end
        foreach (frame_build[i]) begin
            frame_bytes_q.push_back('{data: frame_build[i],
                                      last: (i == frame_build.size() - 1),
                                      err: 1'b0});
        end
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(12, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // Offer one item, hold it until accepted, then maybe idle for a while.
    // push stays high across back-to-back items, so it is never lowered and
    // raised in the same step.
    task automatic send_item(input mbrtu_pkg::t_func f, input logic [15:0] a,
                             input logic [15:0] q, input logic [15:0] w,
                             input logic typed_err);
        push        <= 1'b1;
        i_func      <= f;
        i_reg_addr  <= a;
        i_quantity  <= q;
        i_data_word <= w;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        items_sent++;
        if (typed_err) begin
            expect_error();
        end else begin
            encode_request(f, a, q, w);
        end
        if (tx_idle_on && $urandom_range(0, 2) == 0) begin
            push <= 1'b0;
            repeat (gap_len()) @(posedge i_clk);
        end
    endtask

    task automatic send_random(input mbrtu_pkg::t_func f);
        send_item(f, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
    endtask

    // Stop offering and wait for every expected byte, plus the block latency.
    task automatic wait_drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (frame_bytes_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_slave_address(input logic [7:0] v);
        wait_drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        pred_slave = v;
        i_cfg_we <= 1'b0;
    endtask

    // Write-multiple frame of n words with random content. Now and then
    // inject a header mid-frame; a broken frame stops short of its last word.
    task automatic send_multi_frame(input int n, input bit broken);
        int n_words;
        n_words = broken ? $urandom_range(0, n - 1) : n;
        send_item(mbrtu_pkg::FUNC_WRITE_MULTI, 16'($urandom), 16'(n), 16'($urandom), 1'b0);
        for (int i = 0; i < n_words; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                send_random(mbrtu_pkg::t_func'($urandom_range(0, 2)));
            end
            send_random(mbrtu_pkg::FUNC_DATA_WORD);
        end
    endtask

    task automatic run_random_request();
        int pick;
        int n;
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            send_random(mbrtu_pkg::FUNC_READ_HOLD);
        end else if (pick < 45) begin
            send_random(mbrtu_pkg::FUNC_WRITE_SINGLE);
        end else if (pick < 80) begin
            n = ($urandom_range(0, 11) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            send_multi_frame(n, 1'b0);
        end else if (pick < 87) begin
            send_random(mbrtu_pkg::FUNC_DATA_WORD);
        end else if (pick < 93) begin
            n = $urandom_range(0, 3);
            send_item(mbrtu_pkg::FUNC_WRITE_MULTI, 16'($urandom),
                      (n == 0) ? 16'hFFFF : 16'($urandom_range(MAX_REGS + 1, 65535)),
                      16'($urandom), 1'b0);
        end else begin
            send_multi_frame($urandom_range(1, 6), 1'b1);
        end
    endtask

    // Close any open frame, then run one long frame of n words without gaps.
    task automatic send_long_frame(input int n);
        tx_idle_on = 1'b0;
        while (pred_open) begin
            send_random(mbrtu_pkg::FUNC_DATA_WORD);
        end
        send_item(mbrtu_pkg::FUNC_WRITE_MULTI, 16'($urandom), 16'(n), 16'($urandom), 1'b0);
        for (int i = 0; i < n; i++) begin
            send_random(mbrtu_pkg::FUNC_DATA_WORD);
        end
    endtask

    // Check each popped byte against the oldest expectation; track idle cycles
    // for the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (frame_bytes_q.size() == 0) begin
                $error("unexpected item: tx_byte %h last %b err %b",
                       o_tx_byte, o_last_byte, o_request_error);
                fail_cnt++;
            end else begin
                want = frame_bytes_q.pop_front();
                if (o_tx_byte !== want.data) begin
                    $error("tx_byte: expected %h, got %h", want.data, o_tx_byte);
                    fail_cnt++;
                end
                if (o_last_byte !== want.last) begin
                    $error("last_byte: expected %b, got %b", want.last, o_last_byte);
                    fail_cnt++;
                end
                if (o_request_error !== want.err) begin
                    $error("request_error: expected %b, got %b", want.err, o_request_error);
                    fail_cnt++;
                end
            end
        end
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: pop freely, stall at random, or hold off for a long stretch
    // on request so the block backs up and raises full.
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                pop <= 1'b0;
                repeat (gap_len()) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    initial begin
        @(posedge i_clk);
        while (idle_cycles < WATCHDOG_IDLE) begin
            @(posedge i_clk);
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        directed_rows = '{
            // fields at both extremes, right after reset (slave address 1)
            '{1'b0, 8'h00, mbrtu_pkg::FUNC_READ_HOLD, 16'h0000, 16'h0000, 16'hFFFF, 1'b0},
            '{1'b0, 8'h00, mbrtu_pkg::FUNC_READ_HOLD, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0},
            '{1'b0, 8'h00, mbrtu_pkg::FUNC_WRITE_SINGLE, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0},
            '{1'b0, 8'h00, mbrtu_pkg::FUNC_WRITE_SINGLE, 16'h0000, 16'hFFFF, 16'h0000, 1'b0},
            // stray data word, count one above the limit, count at maximum
            '{1'b0, 8'h00, mbrtu_pkg::FUNC_DATA_WORD, 16'h0000, 16'h0000, 16'hFFFF, 1'b1},
            '{1'b0, 8'h00, mbrtu_pkg::FUNC_WRITE_MULTI, 16'h0000, 16'd124, 16'h0000, 1'b1},
            '{1'b0, 8'h00, mbrtu_pkg::FUNC_WRITE_MULTI, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1},
            // zero count: header plus CRC at once
            '{1'b0, 8'h00, mbrtu_pkg::FUNC_WRITE_MULTI, 16'h1234, 16'h0000, 16'h0000, 1'b0},
            // open a two-word frame, then headers mid-frame
            '{1'b0, 8'h00, mbrtu_pkg::FUNC_WRITE_MULTI, 16'hA55A, 16'h0002, 16'h0000, 1'b0},
            '{1'b0, 8'h00, mbrtu_pkg::FUNC_READ_HOLD, 16'h0001, 16'h0001, 16'h0000, 1'b1},
            '{1'b0, 8'h00, mbrtu_pkg::FUNC_WRITE_MULTI, 16'h0002, 16'h0001, 16'h0000, 1'b1},
            '{1'b0, 8'h00, mbrtu_pkg::FUNC_WRITE_SINGLE, 16'h0003, 16'h0004, 16'h0000, 1'b1},
            '{1'b0, 8'h00, mbrtu_pkg::FUNC_DATA_WORD, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0},
            '{1'b0, 8'h00, mbrtu_pkg::FUNC_DATA_WORD, 16'h0000, 16'h0000, 16'hFFFF, 1'b0},
            // address change while a frame is open hits only later frames
            '{1'b0, 8'h00, mbrtu_pkg::FUNC_WRITE_MULTI, 16'h00FF, 16'h0001, 16'h0000, 1'b0},
            '{1'b1, 8'hFF, mbrtu_pkg::FUNC_DATA_WORD, 16'h0000, 16'h0000, 16'h8001, 1'b0},
            '{1'b0, 8'h00, mbrtu_pkg::FUNC_READ_HOLD, 16'h0102, 16'h007D, 16'h0000, 1'b0},
            '{1'b1, 8'h00, mbrtu_pkg::FUNC_WRITE_MULTI, 16'h0F0F, 16'h0003, 16'h0000, 1'b0},
            '{1'b0, 8'h00, mbrtu_pkg::FUNC_DATA_WORD, 16'h0000, 16'h0000, 16'h5AA5, 1'b0},
            '{1'b0, 8'h00, mbrtu_pkg::FUNC_DATA_WORD, 16'h0000, 16'h0000, 16'hA55A, 1'b0},
            '{1'b0, 8'h00, mbrtu_pkg::FUNC_DATA_WORD, 16'h0000, 16'h0000, 16'h7FFE, 1'b0},
            '{1'b0, 8'h00, mbrtu_pkg::FUNC_DATA_WORD, 16'h0000, 16'h0000, 16'h0000, 1'b1},
            '{1'b1, 8'h01, mbrtu_pkg::FUNC_WRITE_SINGLE, 16'h8000, 16'h0001, 16'h0000, 1'b0}
        };

        fail_cnt    = 0;
        items_sent  = 0;
        idle_cycles = 0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        hold_req    = 1'b0;
        pred_slave  = 8'h01;
        pred_crc    = mbrtu_pkg::CRC_INIT;
        pred_words  = 7'd0;
        pred_open   = 1'b0;

        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        pop         <= 1'b0;
        i_func      <= mbrtu_pkg::FUNC_READ_HOLD;
        i_reg_addr  <= 16'h0000;
        i_quantity  <= 16'h0000;
        i_data_word <= 16'h0000;
        i_cfg_we    <= 1'b0;
        i_cfg_data  <= 8'h00;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; config rows drain the block before the write.
        foreach (directed_rows[r]) begin
            if (directed_rows[r].set_cfg) begin
                write_slave_address(directed_rows[r].cfg_val);
            end
            send_item(directed_rows[r].func, directed_rows[r].addr, directed_rows[r].qty,
                      directed_rows[r].word, directed_rows[r].typed_err);
        end

        // Random phases, each under its own slave address, extremes included.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0:       write_slave_address(8'hA5);
                1:       write_slave_address(8'h00);
                2:       write_slave_address(8'hFF);
                default: write_slave_address(8'($urandom));
            endcase
            if (ph == 1) begin
                // long receiver hold-off while requests keep coming
                hold_req = 1'b1;
                send_long_frame(LONG_WORDS);
            end
            while (items_sent < N_DIRECTED + (ph + 1) * PHASE_ITEMS) begin
                run_random_request();
                if (ph == 2 && items_sent > N_DIRECTED + 2 * PHASE_ITEMS + 10
                        && frame_bytes_q.size() != 0 && !tx_idle_on) begin
                    // pause the sender until every byte so far is out
                    wait_drain();
                end
            end
        end

        wait_drain();
        repeat (12) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/mbrtu_pkg.sv
hdl/mbrtu_front.sv
hdl/mbrtu_cmdq.sv
hdl/mbrtu_back.sv
hdl/modbus_rtu_request_encoder.sv
tb/tb_modbus_rtu_request_encoder.sv
